FILE: hdl/dll_pkg.sv
// ----------------------------------------------------------------------------
// Linked list engine package
// Opcodes and status codes used by the engine, and the result record used by the testbench.
// ----------------------------------------------------------------------------
package dll_pkg;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DELETE   = 3'd3,
        OP_SEARCH   = 3'd4,
        OP_READ_FWD = 3'd5,
        OP_READ_BWD = 3'd6,
        OP_CLEAR    = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RANGE     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_code_t;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  position;
        logic [31:0] element_value;
        logic        last;
    } result_t;

endpackage

FILE: hdl/dll_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/doubly_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine
// Inserts at head or tail and clear need no list walk; search, delete,
// position insert and reads walk the list node by node, because each link
// is fetched from the node memory, whose read data is registered, before
// the next node can be addressed. Each result transfer can stall the engine
// while m_tready is low, and no new item is taken until the result is taken.
// A read sends one transfer per element. Node values and links live in one node
// memory; the used map, head, tail and count are registers.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_unit
    import dll_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], value[34:3], position_index[39:35]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], position[6:3], element_value[38:7]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    localparam int SW = $clog2(CAPACITY);
    localparam int PW = SW + 1;
    localparam int NW = 32 + 2 * PW;
    localparam logic [PW-1:0] NONE = PW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_WALK_REQ, S_WALK_CHK, S_LINK_A, S_LINK_B, S_LINK_C,
        S_DEL_A, S_DEL_B, S_DEL_C, S_OUT
    } state_t;

    state_t state_reg;
    logic [CAPACITY-1:0] used_reg;
    logic [PW-1:0] head_reg, tail_reg, count_reg, cur_reg, pred_reg, succ_reg;
    logic [PW-1:0] step_reg, target_reg, new_reg;
    logic [2:0]  op_reg;
    logic [31:0] val_reg;
    logic        out_valid_reg, out_last_reg;
    logic [2:0]  out_status_reg;
    logic [3:0]  out_pos_reg;
    logic [31:0] out_val_reg;

    logic          we;
    logic [SW-1:0] waddr, raddr;
    logic [NW-1:0] wdata, rdata;
    logic [31:0]   rd_val;
    logic [PW-1:0] rd_next, rd_prev;

    assign rd_val  = rdata[31:0];
    assign rd_next = rdata[32 +: PW];
    assign rd_prev = rdata[32 + PW +: PW];

    dll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_nodes (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [PW-1:0] free_slot;
    always_comb begin
        free_slot = NONE;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (!used_reg[k]) begin
                free_slot = PW'(k);
            end
        end
    end

    logic [2:0]  in_op;
    logic [31:0] in_val;
    logic [4:0]  in_idx;
    assign in_op  = s_tdata[2:0];
    assign in_val = s_tdata[34:3];
    assign in_idx = s_tdata[39:35];

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_val_reg, out_pos_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // Node memory port control, driven from the state and walk registers.
    always_comb begin
        we    = 1'b0;
        waddr = new_reg[SW-1:0];
        wdata = {pred_reg, succ_reg, val_reg};
        raddr = cur_reg[SW-1:0];
        unique case (state_reg)
            S_LINK_A: begin
                we    = 1'b1;
                waddr = new_reg[SW-1:0];
                wdata = {pred_reg, succ_reg, val_reg};
                raddr = pred_reg[SW-1:0];
            end
            S_LINK_B: begin
                raddr = succ_reg[SW-1:0];
                if (pred_reg != NONE) begin
                    we    = 1'b1;
                    waddr = pred_reg[SW-1:0];
                    wdata = {rd_prev, new_reg, rd_val};
                end
            end
            S_LINK_C: begin
                if (succ_reg != NONE) begin
                    we    = 1'b1;
                    waddr = succ_reg[SW-1:0];
                    wdata = {new_reg, rd_next, rd_val};
                end
            end
            S_DEL_A: raddr = pred_reg[SW-1:0];
            S_DEL_B: begin
                raddr = succ_reg[SW-1:0];
                if (pred_reg != NONE) begin
                    we    = 1'b1;
                    waddr = pred_reg[SW-1:0];
                    wdata = {rd_prev, succ_reg, rd_val};
                end
            end
            S_DEL_C: begin
                if (succ_reg != NONE) begin
                    we    = 1'b1;
                    waddr = succ_reg[SW-1:0];
                    wdata = {pred_reg, rd_next, rd_val};
                end
            end
            default: ;
        endcase
    end

    task automatic put(input logic [2:0] st, input logic [3:0] p,
                       input logic [31:0] v, input logic l);
        out_valid_reg  <= 1'b1;
        out_status_reg <= st;
        out_pos_reg    <= p;
        out_val_reg    <= v;
        out_last_reg   <= l;
    endtask

    logic [PW-1:0] read_pos;
    assign read_pos = (op_reg == OP_READ_FWD) ? step_reg : count_reg - 1'b1 - step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            head_reg      <= NONE;
            tail_reg      <= NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        op_reg      <= in_op;
                        val_reg     <= in_val;
                        step_reg    <= (in_op == OP_INS_POS) ? PW'(1) : '0;
                        new_reg     <= free_slot;
                        unique case (opcode_t'(in_op))
                            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                                if (in_op == OP_INS_POS && 8'(in_idx) > 8'(count_reg)) begin
                                    put(ST_RANGE, '0, '0, 1'b1);
                                end else if (count_reg >= NONE || free_slot == NONE) begin
                                    put(ST_FULL, '0, '0, 1'b1);
                                end else if (in_op == OP_INS_TAIL) begin
                                    pred_reg  <= tail_reg;
                                    succ_reg  <= NONE;
                                    state_reg <= S_LINK_A;
                                end else if (in_op == OP_INS_HEAD || in_idx == '0) begin
                                    pred_reg  <= NONE;
                                    succ_reg  <= head_reg;
                                    state_reg <= S_LINK_A;
                                end else begin
                                    target_reg <= PW'(in_idx);
                                    cur_reg    <= head_reg;
                                    state_reg  <= S_WALK_REQ;
                                end
                            end
                            OP_DELETE, OP_SEARCH: begin
                                if (head_reg == NONE) begin
                                    put(ST_NOT_FOUND, '0, '0, 1'b1);
                                end else begin
                                    cur_reg   <= head_reg;
                                    state_reg <= S_WALK_REQ;
                                end
                            end
                            OP_READ_FWD, OP_READ_BWD: begin
                                if (count_reg == '0) begin
                                    put(ST_EMPTY, '0, '0, 1'b1);
                                end else begin
                                    cur_reg   <= (in_op == OP_READ_FWD) ? head_reg : tail_reg;
                                    state_reg <= S_WALK_REQ;
                                end
                            end
                            OP_CLEAR: begin
                                used_reg  <= '0;
                                head_reg  <= NONE;
                                tail_reg  <= NONE;
                                count_reg <= '0;
                                put(ST_OK, '0, '0, 1'b1);
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK_REQ: begin
                    if (!out_valid_reg || m_tready) begin
                        state_reg <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK: begin
                    priority case (1'b1)
                        (op_reg == OP_INS_POS): begin
                            if (step_reg == target_reg || rd_next == NONE) begin
                                pred_reg  <= cur_reg;
                                succ_reg  <= rd_next;
                                state_reg <= S_LINK_A;
                            end else begin
                                cur_reg   <= rd_next;
                                step_reg  <= step_reg + 1'b1;
                                state_reg <= S_WALK_REQ;
                            end
                        end
                        (op_reg == OP_READ_FWD || op_reg == OP_READ_BWD): begin
                            logic [PW-1:0] nx;
                            logic          fin;
                            nx  = (op_reg == OP_READ_FWD) ? rd_next : rd_prev;
                            fin = (nx == NONE) || (step_reg + 1'b1 == count_reg)
                                  || (step_reg == PW'(MAX_RESULTS - 1));
                            put(ST_OK, read_pos[3:0], rd_val, fin);
                            cur_reg  <= nx;
                            step_reg <= step_reg + 1'b1;
                            state_reg <= fin ? S_OUT : S_WALK_REQ;
                        end
                        default: begin
                            if (used_reg[cur_reg[SW-1:0]] && rd_val == val_reg) begin
                                if (op_reg == OP_SEARCH) begin
                                    put(ST_OK, step_reg[3:0], rd_val, 1'b1);
                                    state_reg <= S_OUT;
                                end else begin
                                    target_reg <= cur_reg;
                                    pred_reg   <= rd_prev;
                                    succ_reg   <= rd_next;
                                    state_reg  <= S_DEL_A;
                                end
                            end else if (rd_next == NONE || step_reg == NONE - 1'b1) begin
                                put(ST_NOT_FOUND, '0, '0, 1'b1);
                                state_reg <= S_OUT;
                            end else begin
                                cur_reg   <= rd_next;
                                step_reg  <= step_reg + 1'b1;
                                state_reg <= S_WALK_REQ;
                            end
                        end
                    endcase
                end
                S_LINK_A: state_reg <= S_LINK_B;
                S_LINK_B: begin
                    if (pred_reg == NONE) begin
                        head_reg <= new_reg;
                    end
                    state_reg <= S_LINK_C;
                end
                S_LINK_C: begin
                    if (succ_reg == NONE) begin
                        tail_reg <= new_reg;
                    end
                    used_reg[new_reg[SW-1:0]] <= 1'b1;
                    count_reg <= count_reg + 1'b1;
                    put(ST_OK, '0, '0, 1'b1);
                    state_reg <= S_OUT;
                end
                S_DEL_A: state_reg <= S_DEL_B;
                S_DEL_B: begin
                    if (pred_reg == NONE) begin
                        head_reg <= succ_reg;
                    end
                    state_reg <= S_DEL_C;
                end
                S_DEL_C: begin
                    if (succ_reg == NONE) begin
                        tail_reg <= pred_reg;
                    end
                    used_reg[target_reg[SW-1:0]] <= 1'b0;
                    if (count_reg != '0) begin
                        count_reg <= count_reg - 1'b1;
                    end
                    put(ST_OK, step_reg[3:0], '0, 1'b1);
                    state_reg <= S_OUT;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Walk requests wait for the output register before a read emits again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK_CHK) |-> $past(state_reg) == S_WALK_REQ)
        else $error("walk check without a preceding node fetch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NONE)
        else $error("element count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && count_reg == '0) |-> (head_reg == NONE && tail_reg == NONE))
        else $error("empty list keeps a head or tail");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINK_C) |=> $countones(used_reg) == $past($countones(used_reg)) + 1)
        else $error("insert did not mark its slot");
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives directed and random list operations over the stream input, keeps a
// behavioral copy of the list to predict every result transfer, and compares
// each result field by field under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import dll_pkg::*;

    localparam int CAP = 16;
    localparam int NONE = CAP;
    localparam int RANDOM_ITEMS = 445;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] value;
        logic [4:0]  pos_index;
    } list_cmd_t;

    typedef struct {
        list_cmd_t cmd;
        bit        fixed;
        logic [2:0] status;
    } cmd_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    logic [31:0] list_value [CAP];
    int          list_next [CAP];
    int          list_prev [CAP];
    bit          list_used [CAP];
    int          list_head;
    int          list_tail;
    int          list_count;

    result_t     pending_results [$];
    logic [31:0] known_values [$];
    cmd_row_t    directed_rows [$];
    int          mismatches;
    int          cycles;

    doubly_linked_list_engine_unit #(.CAPACITY(CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic result_t make_result(logic [2:0] st, int pos, logic [31:0] v, bit lst);
        result_t r;
        r.status = st;
        r.position = pos[3:0];
        r.element_value = v;
        r.last = lst;
        return r;
    endfunction

    function automatic int find_first(logic [31:0] v, output int pos);
        int s;
        int i;
        s = list_head;
        i = 0;
        pos = 0;
        while (s < CAP && i < CAP) begin
            if (list_used[s] && list_value[s] == v) begin
                pos = i;
                return s;
            end
            s = list_next[s];
            i++;
        end
        return NONE;
    endfunction

    // Applies one command to the list copy and queues the transfers it causes.
    function automatic void predict_list_op(list_cmd_t c);
        int s;
        int pred;
        int succ;
        int pos;
        int n;
        int i;
        case (opcode_t'(c.opcode))
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (c.opcode == OP_INS_POS && c.pos_index > list_count) begin
                    pending_results.push_back(make_result(ST_RANGE, 0, 0, 1));
                    return;
                end
                s = NONE;
                for (i = CAP - 1; i >= 0; i--) if (!list_used[i]) s = i;
                if (s == NONE) begin
                    pending_results.push_back(make_result(ST_FULL, 0, 0, 1));
                    return;
                end
                pred = NONE;
                if (c.opcode == OP_INS_TAIL) begin
                    pred = list_tail;
                end else if (c.opcode == OP_INS_POS && c.pos_index > 0) begin
                    pred = list_head;
                    for (i = 1; i < c.pos_index && pred < CAP; i++) pred = list_next[pred];
                end
                succ = (pred < CAP) ? list_next[pred] : list_head;
                list_value[s] = c.value;
                list_used[s] = 1'b1;
                list_prev[s] = pred;
                list_next[s] = succ;
                if (pred < CAP) list_next[pred] = s; else list_head = s;
                if (succ < CAP) list_prev[succ] = s; else list_tail = s;
                list_count++;
                known_values.push_back(c.value);
                pending_results.push_back(make_result(ST_OK, 0, 0, 1));
            end
            OP_DELETE: begin
                s = find_first(c.value, pos);
                if (s == NONE) begin
                    pending_results.push_back(make_result(ST_NOT_FOUND, 0, 0, 1));
                    return;
                end
                pred = list_prev[s];
                succ = list_next[s];
                if (pred < CAP) list_next[pred] = succ; else list_head = succ;
                if (succ < CAP) list_prev[succ] = pred; else list_tail = pred;
                list_used[s] = 1'b0;
                if (list_count > 0) list_count--;
                pending_results.push_back(make_result(ST_OK, pos, 0, 1));
            end
            OP_SEARCH: begin
                s = find_first(c.value, pos);
                if (s == NONE) pending_results.push_back(make_result(ST_NOT_FOUND, 0, 0, 1));
                else pending_results.push_back(make_result(ST_OK, pos, list_value[s], 1));
            end
            OP_READ_FWD, OP_READ_BWD: begin
                if (list_count == 0) begin
                    pending_results.push_back(make_result(ST_EMPTY, 0, 0, 1));
                    return;
                end
                n = (list_count < MAX_RESULTS) ? list_count : MAX_RESULTS;
                s = (c.opcode == OP_READ_FWD) ? list_head : list_tail;
                for (i = 0; i < n && s < CAP; i++) begin
                    pos = (c.opcode == OP_READ_FWD) ? i : list_count - 1 - i;
                    pending_results.push_back(make_result(ST_OK, pos, list_value[s],
                                                          (i == n - 1)));
                    s = (c.opcode == OP_READ_FWD) ? list_next[s] : list_prev[s];
                end
            end
            default: begin
                for (i = 0; i < CAP; i++) list_used[i] = 1'b0;
                list_head = NONE;
                list_tail = NONE;
                list_count = 0;
                pending_results.push_back(make_result(ST_OK, 0, 0, 1));
            end
        endcase
    endfunction

    function automatic list_cmd_t make_cmd(opcode_t op, logic [31:0] v, logic [4:0] idx);
        list_cmd_t c;
        c.opcode = op;
        c.value = v;
        c.pos_index = idx;
        return c;
    endfunction

    function automatic void add_row(opcode_t op, logic [31:0] v, logic [4:0] idx, bit fixed,
                                    status_code_t st);
        cmd_row_t r;
        r.cmd = make_cmd(op, v, idx);
        r.fixed = fixed;
        r.status = st;
        directed_rows.push_back(r);
    endfunction

    task automatic send_cmd(list_cmd_t c);
        s_tdata <= {c.pos_index, c.value, c.opcode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_list_op(c);
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    function automatic list_cmd_t random_cmd();
        logic [31:0] v;
        int r;
        int op;
        r = $urandom_range(0, 99);
        if (known_values.size() > 0 && $urandom_range(0, 2) != 0)
            v = known_values[$urandom_range(0, known_values.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 7);
        else
            v = $urandom;
        if (r < 22) op = OP_INS_TAIL;
        else if (r < 38) op = OP_INS_HEAD;
        else if (r < 54) op = OP_INS_POS;
        else if (r < 70) op = OP_DELETE;
        else if (r < 82) op = OP_SEARCH;
        else if (r < 89) op = OP_READ_FWD;
        else if (r < 96) op = OP_READ_BWD;
        else op = OP_CLEAR;
        return make_cmd(opcode_t'(op), v,
                        ($urandom_range(0, 4) == 0) ? 5'($urandom) :
                                                      5'($urandom_range(0, list_count)));
    endfunction

    // Receiver stalls in its own pattern: runs of readiness and runs of stall.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = make_result(m_tdata[2:0], m_tdata[6:3], m_tdata[38:7], m_tlast);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transfer %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected st=%0d pos=%0d val=%h last=%b, got st=%0d pos=%0d val=%h last=%b",
                                 want.status, want.position, want.element_value, want.last,
                                 got.status, got.position, got.element_value, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int i;
        int settle;
        list_cmd_t c;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        cycles = 0;
        list_head = NONE;
        list_tail = NONE;
        list_count = 0;
        for (i = 0; i < CAP; i++) list_used[i] = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(OP_READ_FWD, 0, 0, 1, ST_EMPTY);
        add_row(OP_DELETE, 32'h5, 0, 1, ST_NOT_FOUND);
        add_row(OP_SEARCH, 32'h5, 0, 1, ST_NOT_FOUND);
        add_row(OP_INS_POS, 32'h1, 5'd1, 1, ST_RANGE);
        add_row(OP_INS_POS, 32'h1, 5'd31, 1, ST_RANGE);
        add_row(OP_INS_POS, 32'h8000_0000, 5'd0, 1, ST_OK);
        add_row(OP_INS_TAIL, 32'h7FFF_FFFF, 0, 1, ST_OK);
        add_row(OP_INS_HEAD, 32'hFFFF_FFFF, 0, 1, ST_OK);
        add_row(OP_INS_POS, 32'h0, 5'd3, 0, ST_OK);
        add_row(OP_INS_POS, 32'h1234_5678, 5'd2, 0, ST_OK);
        add_row(OP_SEARCH, 32'h7FFF_FFFF, 0, 0, ST_OK);
        add_row(OP_READ_FWD, 0, 0, 0, ST_OK);
        add_row(OP_READ_BWD, 0, 0, 0, ST_OK);
        add_row(OP_DELETE, 32'hFFFF_FFFF, 0, 0, ST_OK);
        add_row(OP_DELETE, 32'h0, 0, 0, ST_OK);
        for (i = 0; i < 13; i++) add_row(OP_INS_TAIL, 32'(i * 3), 0, 0, ST_OK);
        add_row(OP_INS_HEAD, 32'h55, 0, 1, ST_FULL);
        add_row(OP_INS_POS, 32'h55, 5'd16, 1, ST_FULL);
        add_row(OP_INS_POS, 32'h55, 5'd17, 1, ST_RANGE);
        add_row(OP_READ_BWD, 0, 0, 0, ST_OK);
        add_row(OP_CLEAR, 0, 0, 1, ST_OK);
        add_row(OP_READ_BWD, 0, 0, 1, ST_EMPTY);

        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].cmd);
            if (directed_rows[k].fixed && pending_results[$].status != directed_rows[k].status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Table row %0d: predicted status %0d, table says %0d",
                             k, pending_results[$].status, directed_rows[k].status);
            end
            idle_gap();
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge aclk);
            end
            c = random_cmd();
            send_cmd(c);
            if ($urandom_range(0, 7) == 0) idle_gap();
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        settle = 0;
        while (settle < 200) begin
            @(posedge aclk);
            settle++;
        end
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
